/* design/jefc_pkg.sv */
// Package for the jitter entropy FNV collector: opcodes, command kinds, run phases,
// the queue entry type and the FNV-1a fold function.
// Depends on nothing; the top level, the front end and the back end import it.
package jefc_pkg;

   localparam int unsigned SAMPLE_RUNS_DEF = 32;
   localparam int unsigned QUEUE_DEPTH     = 2;

   localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
   localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

   localparam logic [31:0] PRIME_TIMEOUT_RESET = 32'd5000000;
   localparam logic [31:0] EDGE_TIMEOUT_RESET  = 32'd200000;

   // Request opcodes as they arrive on the input channel.
   localparam logic [1:0] OP_RESTART = 2'd0;
   localparam logic [1:0] OP_ABSORB  = 2'd1;
   localparam logic [1:0] OP_START   = 2'd2;
   localparam logic [1:0] OP_TICK    = 2'd3;

   // Register indexes of the configuration port.
   localparam logic REG_PRIME_TIMEOUT = 1'b0;
   localparam logic REG_EDGE_TIMEOUT  = 1'b1;

   typedef enum logic [1:0] {
      CMD_RESTART,
      CMD_ABSORB,
      CMD_START,
      CMD_TICK
   } cmd_kind_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PRIME,
      PH_SAMPLE,
      PH_DONE
   } run_phase_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data_byte;
      logic [31:0]  lsi_count;
      logic [31:0]  tick_count;
   } queue_entry_type;

   // Queue head as seen by the back end.
   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_head_type;

   // One FNV-1a step: xor the byte in, then multiply by the FNV prime modulo 2^32.
   function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] x;
      x = h ^ {24'd0, b};
      return x * FNV_PRIME;
   endfunction

endpackage

/* design/jefc_req_if.sv */
// Request channel of the jitter entropy collector: valid/ready plus the request fields.
// Stands alone; the top level and the front end use its sink modport.
interface jefc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [7:0]  data_byte;
   logic [31:0] lsi_count;
   logic [31:0] tick_count;

   modport source (output valid, output op, output data_byte, output lsi_count,
                   output tick_count, input ready);
   modport sink   (input valid, input op, input data_byte, input lsi_count,
                   input tick_count, output ready);
endinterface

/* design/jefc_rsp_if.sv */
// Response channel of the jitter entropy collector: valid/ready plus the result fields.
// Stands alone; the top level and the back end use its modports.
interface jefc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] entropy_word;
   logic [1:0]  run_phase;
   logic [5:0]  samples_folded;
   logic        clock_dead;

   modport source (output valid, output entropy_word, output run_phase,
                   output samples_folded, output clock_dead, input ready);
   modport sink   (input valid, input entropy_word, input run_phase,
                   input samples_folded, input clock_dead, output ready);
endinterface

/* design/jitter_entropy_fnv_collector.sv */
// Top level of the clock-jitter entropy collector built on a 32-bit FNV-1a word.
// Depends on jefc_pkg, jefc_req_if, jefc_rsp_if, jefc_front and jefc_back.
//
// Requests arrive on req_bus (valid/ready). Each request carries an opcode:
// restart loads the FNV offset basis, absorb folds one memory byte, start begins
// a jitter run, and tick presents the fast tick counter with the slow oscillator
// counter. Every request yields exactly one response on rsp_bus with the hash word,
// the run phase, the samples folded so far and the dead-clock flag.
//
// A request lands in a two-entry queue on the accepting edge; the back end takes it
// from the queue head and registers the response in the response register. The back
// end gives one response per cycle while rsp ready stays high; a tick that sees a
// slow-clock edge while sampling folds two bytes in turn, the delta byte and then
// the tick byte, and holds the queue head until the second fold is done.
//
// Reset (synchronous, active high) restores the basis, the idle phase, the default
// timeouts and an empty queue; nothing needs a clearing pass. When the receiver
// holds rsp ready low, the response register keeps its value, the queue fills and
// req ready drops once both entries are taken.
//
// The APB port writes the prime timeout at address 0 and the edge timeout at 4.
module jitter_entropy_fnv_collector #(
   parameter int unsigned SAMPLE_RUNS = jefc_pkg::SAMPLE_RUNS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   jefc_req_if.sink    req_bus,
   jefc_rsp_if.source  rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import jefc_pkg::*;

   logic [31:0]    prime_timeout_ff;
   logic [31:0]    edge_timeout_ff;
   logic           csr_write;
   logic           reg_index;
   queue_head_type head;
   logic           pop;

   // Registers sit at 4-byte strides; bit 2 of the address picks the register.
   assign pready    = 1'b1;
   assign reg_index = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prime_timeout_ff <= PRIME_TIMEOUT_RESET;
         edge_timeout_ff  <= EDGE_TIMEOUT_RESET;
      end else if (csr_write) begin
         case (reg_index)
            REG_PRIME_TIMEOUT: prime_timeout_ff <= pwdata;
            REG_EDGE_TIMEOUT:  edge_timeout_ff  <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_PRIME_TIMEOUT: prdata = prime_timeout_ff;
         REG_EDGE_TIMEOUT:  prdata = edge_timeout_ff;
         default:           prdata = '0;
      endcase
   end

   // The front end classifies and queues requests; the back end executes them.
   jefc_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .pop   (pop),
      .head  (head)
   );

   jefc_back #(
      .SAMPLE_RUNS (SAMPLE_RUNS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .prime_timeout (prime_timeout_ff),
      .edge_timeout  (edge_timeout_ff),
      .rsp           (rsp_bus)
   );

endmodule

/* design/jefc_front.sv */
// Front end: accepts requests, classifies the opcode and holds them in a short queue.
// Depends on jefc_pkg and jefc_req_if.
module jefc_front (
   input  logic                     clock,
   input  logic                     reset,
   jefc_req_if.sink                 req,
   input  logic                     pop,
   output jefc_pkg::queue_head_type head
);
   import jefc_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   queue_entry_type  slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   queue_entry_type  incoming;
   logic             push;

   always_comb begin
      case (req.op)
         OP_RESTART: incoming.kind = CMD_RESTART;
         OP_ABSORB:  incoming.kind = CMD_ABSORB;
         OP_START:   incoming.kind = CMD_START;
         OP_TICK:    incoming.kind = CMD_TICK;
         default:    incoming.kind = CMD_TICK;
      endcase
      incoming.data_byte  = req.data_byte;
      incoming.lsi_count  = req.lsi_count;
      incoming.tick_count = req.tick_count;
   end

   assign req.ready = (count_ff != FULL_CNT);
   assign push      = req.valid && req.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= incoming;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = slots_ff[rd_ptr_ff];

endmodule

/* design/jefc_back.sv */
// Back end: runs the jitter sequencer, folds bytes into the FNV word and registers results.
// Depends on jefc_pkg and jefc_rsp_if; takes requests from the front-end queue.
module jefc_back #(
   parameter int unsigned SAMPLE_RUNS = jefc_pkg::SAMPLE_RUNS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  jefc_pkg::queue_head_type head,
   output logic                     pop,
   input  logic [31:0]              prime_timeout,
   input  logic [31:0]              edge_timeout,
   jefc_rsp_if.source               rsp
);
   import jefc_pkg::*;

   localparam logic [5:0] RUNS_LIMIT = 6'(SAMPLE_RUNS);

   typedef enum logic {
      ST_EXEC,
      ST_FOLD2
   } seq_state_type;

   seq_state_type state_ff, state_in;
   logic [31:0]   hash_ff, hash_in;
   run_phase_type phase_ff, phase_in;
   logic [31:0]   slow_ref_ff, slow_ref_in;
   logic [31:0]   wait_start_ff, wait_start_in;
   logic [31:0]   prev_edge_ff, prev_edge_in;
   logic [5:0]    count_ff, count_in;
   logic          dead_ff, dead_in;
   logic          rsp_valid_ff;
   logic [31:0]   rsp_word_ff;
   logic [1:0]    rsp_phase_ff;
   logic [5:0]    rsp_count_ff;
   logic          rsp_dead_ff;

   logic          emit;
   logic          out_free;
   logic          changed;
   logic [31:0]   delta;
   logic [31:0]   elapsed;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign changed  = (head.entry.lsi_count != slow_ref_ff);
   assign delta    = head.entry.tick_count - prev_edge_ff;
   assign elapsed  = head.entry.tick_count - wait_start_ff;

   always_comb begin
      state_in      = state_ff;
      hash_in       = hash_ff;
      phase_in      = phase_ff;
      slow_ref_in   = slow_ref_ff;
      wait_start_in = wait_start_ff;
      prev_edge_in  = prev_edge_ff;
      count_in      = count_ff;
      dead_in       = dead_ff;
      pop           = 1'b0;
      emit          = 1'b0;
      case (state_ff)
         ST_EXEC: begin
            if (head.valid && out_free) begin
               pop  = 1'b1;
               emit = 1'b1;
               case (head.entry.kind)
                  CMD_RESTART: begin
                     hash_in = FNV_BASIS;
                  end
                  CMD_ABSORB: begin
                     hash_in = fnv_fold(hash_ff, head.entry.data_byte);
                  end
                  CMD_START: begin
                     slow_ref_in   = head.entry.lsi_count;
                     wait_start_in = head.entry.tick_count;
                     count_in      = '0;
                     dead_in       = 1'b0;
                     phase_in      = PH_PRIME;
                  end
                  CMD_TICK: begin
                     case (phase_ff)
                        PH_PRIME: begin
                           if (changed) begin
                              prev_edge_in  = head.entry.tick_count;
                              slow_ref_in   = head.entry.lsi_count;
                              wait_start_in = head.entry.tick_count;
                              phase_in      = PH_SAMPLE;
                           end else if (elapsed >= prime_timeout) begin
                              dead_in  = 1'b1;
                              phase_in = PH_DONE;
                           end
                        end
                        PH_SAMPLE: begin
                           if (changed) begin
                              // First of two folds; the tick byte follows next cycle.
                              hash_in       = fnv_fold(hash_ff, delta[7:0]);
                              prev_edge_in  = head.entry.tick_count;
                              slow_ref_in   = head.entry.lsi_count;
                              wait_start_in = head.entry.tick_count;
                              count_in      = 6'(count_ff + 6'd1);
                              if (count_in >= RUNS_LIMIT) begin
                                 phase_in = PH_DONE;
                              end
                              state_in = ST_FOLD2;
                              pop      = 1'b0;
                              emit     = 1'b0;
                           end else if (elapsed >= edge_timeout) begin
                              dead_in  = 1'b1;
                              phase_in = PH_DONE;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FOLD2: begin
            if (out_free) begin
               hash_in  = fnv_fold(hash_ff, head.entry.tick_count[7:0]);
               pop      = 1'b1;
               emit     = 1'b1;
               state_in = ST_EXEC;
            end
         end
         default: begin
            state_in = ST_EXEC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_EXEC;
         hash_ff       <= FNV_BASIS;
         phase_ff      <= PH_IDLE;
         slow_ref_ff   <= '0;
         wait_start_ff <= '0;
         prev_edge_ff  <= '0;
         count_ff      <= '0;
         dead_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hash_ff       <= hash_in;
         phase_ff      <= phase_in;
         slow_ref_ff   <= slow_ref_in;
         wait_start_ff <= wait_start_in;
         prev_edge_ff  <= prev_edge_in;
         count_ff      <= count_in;
         dead_ff       <= dead_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (emit) begin
         rsp_word_ff  <= hash_in;
         rsp_phase_ff <= phase_in;
         rsp_count_ff <= count_in;
         rsp_dead_ff  <= dead_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.entropy_word   = rsp_word_ff;
   assign rsp.run_phase      = rsp_phase_ff;
   assign rsp.samples_folded = rsp_count_ff;
   assign rsp.clock_dead     = rsp_dead_ff;

   // The second fold always finds the output register free and completes at once.
   a_fold2_completes: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FOLD2 |=> rsp_valid_ff && state_ff == ST_EXEC)
      else $error("second fold did not complete in one cycle");

   a_dead_means_done: assert property (@(posedge clock) disable iff (reset)
      dead_ff |-> phase_ff == PH_DONE)
      else $error("dead flag set outside the finished phase");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RUNS_LIMIT && (phase_ff != PH_PRIME || count_ff == '0))
      else $error("sample count out of range for the run phase");

endmodule
